// ----- hdl/sma_pkg.sv -----
`timescale 1ns / 1ps
package sma_pkg;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_PRINT = 4'd5,
    OP_STORE = 4'd6,
    OP_FETCH = 4'd7,
    OP_DUP   = 4'd8,
    OP_DROP  = 4'd9,
    OP_SWAP  = 4'd10,
    OP_EQ    = 4'd11,
    OP_LT    = 4'd12,
    OP_GT    = 4'd13
  } op_t;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_OVER  = 3'd2;
  localparam logic [2:0] ERR_DIV0  = 3'd3;
  localparam logic [2:0] ERR_SLOT  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RD_B,
    S_RD_A,
    S_VAR,
    S_MUL,
    S_DIV,
    S_FIX,
    S_WR,
    S_TOP,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;   // write zero to variable store at clear counter
    logic load;       // capture input item and decode checks
    logic rd_b;       // read data stack at sp-1 into b
    logic rd_a;       // read data stack at sp-2 into a
    logic rd_var;     // read variable store at slot b
    logic mul_start;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic div_fix;
    logic exec;       // commit stack / store writes and new pointer
    logic rd_top;     // read new top
    logic out_load;   // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic err_pre;    // underflow / overflow / unused op: skip
    logic need_b;
    logic need_a;
    logic is_var;     // fetch with valid slot
    logic is_mul;
    logic is_div;     // divide with nonzero divisor
    logic count_done;
  } stat_t;

endpackage

// ----- hdl/sma_datapath.sv -----
`timescale 1ns / 1ps
module sma_datapath #(
  parameter int STACK_DEPTH = 64,
  parameter int VAR_SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  sma_pkg::cmd_t    cmd,
  output sma_pkg::stat_t   stat,
  input  logic [3:0]       opcode,
  input  logic [31:0]      literal,
  output logic [31:0]      top_value,
  output logic [6:0]       stack_depth,
  output logic [31:0]      printed_value,
  output logic             printed_valid,
  output logic [2:0]       error_code
);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int VAW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
  localparam int VCW = $clog2(VAR_SLOTS + 1);

  logic [31:0] stk [STACK_DEPTH];
  logic [31:0] vars [VAR_SLOTS];

  logic [SPW-1:0] sp, sp_new;
  logic [VCW-1:0] clr_cnt;
  logic [3:0]  op;
  logic [31:0] lit, a, b, res;
  logic [2:0]  err;
  logic        pre_skip;
  logic        slot_ok;
  logic [5:0]  cnt;
  logic [31:0] prod;
  logic [31:0] mcand, rem, quo, dvs;
  logic        neg_q;
  logic [31:0] rdq;

  logic [1:0] need;
  logic       grow;
  always_comb begin
    need = 2'd2;
    grow = 1'b0;
    unique case (opcode)
      sma_pkg::OP_PUSH: begin need = 2'd0; grow = 1'b1; end
      sma_pkg::OP_PRINT, sma_pkg::OP_FETCH, sma_pkg::OP_DROP: need = 2'd1;
      sma_pkg::OP_DUP: begin need = 2'd1; grow = 1'b1; end
      default: need = 2'd2;
    endcase
  end

  assign slot_ok = !b[31] && ({1'b0, b} < 33'(VAR_SLOTS));
  logic [VAW-1:0] slot;
  assign slot = b[VAW-1:0];

  logic [31:0] sub_r;
  logic        sub_ok;
  assign {sub_ok, sub_r} = {1'b0, rem[30:0], quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_step) begin
        vars[clr_cnt[VAW-1:0]] <= '0;
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.exec) sp <= sp_new;
    end
    if (cmd.load) begin
      op <= opcode;
      lit <= literal;
      pre_skip <= 1'b0;
      err <= sma_pkg::ERR_OK;
      if (opcode > sma_pkg::OP_GT) pre_skip <= 1'b1;
      else if (sp < SPW'(need)) begin
        pre_skip <= 1'b1;
        err <= sma_pkg::ERR_UNDER;
      end else if (grow && sp >= SPW'(STACK_DEPTH)) begin
        pre_skip <= 1'b1;
        err <= sma_pkg::ERR_OVER;
      end
    end
    if (cmd.rd_b) b <= stk[SAW'(sp - 1'b1)];
    if (cmd.rd_a) a <= stk[SAW'(sp - 2'd2)];
    if (cmd.rd_var) res <= vars[slot];
    if (cmd.mul_start) begin
      prod <= '0;
      mcand <= a;
      cnt <= '0;
    end
    if (cmd.mul_step) begin
      prod <= (prod << 1) + (b[31 - cnt[4:0]] ? mcand : 32'd0);
      cnt <= cnt + 1'b1;
    end
    if (cmd.div_start) begin
      quo <= a[31] ? -a : a;
      dvs <= b[31] ? -b : b;
      rem <= '0;
      neg_q <= a[31] ^ b[31];
      cnt <= '0;
    end
    if (cmd.div_step) begin
      if (!sub_ok) begin
        rem <= sub_r;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
    if (cmd.div_fix) res <= neg_q ? -quo : quo;
    if (cmd.exec) begin
      if (!pre_skip) begin
        unique case (op)
          sma_pkg::OP_PUSH:  stk[SAW'(sp)] <= lit;
          sma_pkg::OP_ADD:   stk[SAW'(sp - 2'd2)] <= a + b;
          sma_pkg::OP_SUB:   stk[SAW'(sp - 2'd2)] <= a - b;
          sma_pkg::OP_MUL:   stk[SAW'(sp - 2'd2)] <= prod;
          sma_pkg::OP_DIV:   if (b != '0) stk[SAW'(sp - 2'd2)] <= res;
          sma_pkg::OP_STORE: if (slot_ok) vars[slot] <= a;
          sma_pkg::OP_FETCH: if (slot_ok) stk[SAW'(sp - 1'b1)] <= res;
          sma_pkg::OP_DUP:   stk[SAW'(sp)] <= b;
          sma_pkg::OP_SWAP: begin
            stk[SAW'(sp - 1'b1)] <= a;
            stk[SAW'(sp - 2'd2)] <= b;
          end
          sma_pkg::OP_EQ: stk[SAW'(sp - 2'd2)] <= {31'd0, a == b};
          sma_pkg::OP_LT: stk[SAW'(sp - 2'd2)] <= {31'd0, $signed(a) < $signed(b)};
          sma_pkg::OP_GT: stk[SAW'(sp - 2'd2)] <= {31'd0, $signed(a) > $signed(b)};
          default: ;
        endcase
        if ((op == sma_pkg::OP_DIV && b == '0)) err <= sma_pkg::ERR_DIV0;
        if ((op == sma_pkg::OP_STORE || op == sma_pkg::OP_FETCH) && !slot_ok)
          err <= sma_pkg::ERR_SLOT;
      end
    end
    if (cmd.rd_top) rdq <= stk[SAW'(sp - 1'b1)];
    if (cmd.out_load) begin
      top_value <= (sp == '0) ? 32'd0 : rdq;
      stack_depth <= 7'(sp);
      printed_valid <= !pre_skip && op == sma_pkg::OP_PRINT;
      printed_value <= (!pre_skip && op == sma_pkg::OP_PRINT) ? b : 32'd0;
      error_code <= err;
    end
  end

  always_comb begin
    sp_new = sp;
    if (!pre_skip) begin
      unique case (op)
        sma_pkg::OP_PUSH, sma_pkg::OP_DUP: sp_new = sp + 1'b1;
        sma_pkg::OP_PRINT, sma_pkg::OP_DROP, sma_pkg::OP_ADD, sma_pkg::OP_SUB,
        sma_pkg::OP_MUL, sma_pkg::OP_EQ, sma_pkg::OP_LT, sma_pkg::OP_GT:
          sp_new = sp - 1'b1;
        sma_pkg::OP_DIV: sp_new = (b == '0) ? sp - 2'd2 : sp - 1'b1;
        sma_pkg::OP_STORE: sp_new = sp - 2'd2;
        sma_pkg::OP_FETCH: sp_new = slot_ok ? sp : sp - 1'b1;
        default: sp_new = sp;
      endcase
    end
  end

  assign stat.clr_done = (clr_cnt == VCW'(VAR_SLOTS));
  assign stat.err_pre = pre_skip;
  assign stat.need_b = (op != sma_pkg::OP_PUSH);
  assign stat.need_a = !(op == sma_pkg::OP_PUSH || op == sma_pkg::OP_PRINT ||
                         op == sma_pkg::OP_FETCH || op == sma_pkg::OP_DROP ||
                         op == sma_pkg::OP_DUP);
  assign stat.is_var = (op == sma_pkg::OP_FETCH) && slot_ok;
  assign stat.is_mul = (op == sma_pkg::OP_MUL);
  assign stat.is_div = (op == sma_pkg::OP_DIV) && (b != '0);
  assign stat.count_done = (cnt == 6'd31);
endmodule

// ----- hdl/sma_ctrl.sv -----
`timescale 1ns / 1ps
module sma_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sma_pkg::stat_t  stat,
  output sma_pkg::cmd_t   cmd
);
  sma_pkg::state_t state, state_next;
  logic ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sma_pkg::S_CLEAR;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
    end
  end

  assign out_valid = ov;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    ov_next = ov && !out_ready;
    unique case (state)
      sma_pkg::S_CLEAR: begin
        if (stat.clr_done) state_next = sma_pkg::S_IDLE;
        else cmd.clr_step = 1'b1;
      end
      sma_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = sma_pkg::S_RD_B;
        end
      end
      sma_pkg::S_RD_B: begin
        if (stat.err_pre) state_next = sma_pkg::S_TOP;
        else begin
          if (stat.need_b) cmd.rd_b = 1'b1;
          state_next = stat.need_a ? sma_pkg::S_RD_A : sma_pkg::S_VAR;
        end
      end
      sma_pkg::S_RD_A: begin
        cmd.rd_a = 1'b1;
        state_next = sma_pkg::S_VAR;
      end
      sma_pkg::S_VAR: begin
        if (stat.is_var) begin
          cmd.rd_var = 1'b1;
          state_next = sma_pkg::S_WR;
        end else if (stat.is_mul) begin
          cmd.mul_start = 1'b1;
          state_next = sma_pkg::S_MUL;
        end else if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next = sma_pkg::S_DIV;
        end else state_next = sma_pkg::S_WR;
      end
      sma_pkg::S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.count_done) state_next = sma_pkg::S_WR;
      end
      sma_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.count_done) state_next = sma_pkg::S_FIX;
      end
      sma_pkg::S_FIX: begin
        cmd.div_fix = 1'b1;
        state_next = sma_pkg::S_WR;
      end
      sma_pkg::S_WR: begin
        cmd.exec = 1'b1;
        state_next = sma_pkg::S_TOP;
      end
      sma_pkg::S_TOP: begin
        cmd.rd_top = 1'b1;
        state_next = sma_pkg::S_OUT;
      end
      sma_pkg::S_OUT: begin
        if (!ov || out_ready) begin
          cmd.out_load = 1'b1;
          ov_next = 1'b1;
          state_next = sma_pkg::S_IDLE;
        end
      end
      default: state_next = sma_pkg::S_IDLE;
    endcase
  end
endmodule

// ----- hdl/stack_machine_alu_unit.sv -----
`timescale 1ns / 1ps
// Stack-machine word executor on a 32-bit data stack with a variable store.
// Input channel in_valid/in_ready carries one item: opcode and literal.
// Output channel out_valid/out_ready carries one result item per input item:
// top_value, stack_depth, printed_value, printed_valid and error_code.
// Items are executed one at a time by a controller and a datapath.
// A word reads its operands, runs an optional compute step, writes the stack
// and reads the new top before its result is loaded; skipped words go from
// the operand step straight to the top read. Multiply takes one bit per cycle
// (32 steps); divide is restoring, one quotient bit per cycle, then a sign fix.
// The shift-add multiplier and the restoring divider set the worst case;
// stack memory reads (one per cycle) set the ordinary case.
// The unit is back in idle in the cycle after loading a result, and only then
// accepts the next item. The output register holds a finished item, so the
// next item is accepted while the previous result waits; only a second result
// stalls the unit. Reset clears the stack pointer, then runs a clearing pass
// that zeroes each of the VAR_SLOTS variable slots with in_ready low.
module stack_machine_alu_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int VAR_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic [31:0] literal,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] top_value,
  output logic [6:0]  stack_depth,
  output logic [31:0] printed_value,
  output logic        printed_valid,
  output logic [2:0]  error_code
);
  sma_pkg::cmd_t  cmd;
  sma_pkg::stat_t stat;

  // sequence the word through read, compute, write and result
  sma_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  // hold the stack, the variable store and the arithmetic units
  sma_datapath #(.STACK_DEPTH(STACK_DEPTH), .VAR_SLOTS(VAR_SLOTS)) u_dp (
    .clk, .rst, .cmd, .stat, .opcode, .literal,
    .top_value, .stack_depth, .printed_value, .printed_valid, .error_code
  );
endmodule

// ----- tb/stack_machine_alu_unit_tb.sv -----
`timescale 1ns / 1ps
module stack_machine_alu_unit_tb;

  localparam int DEPTH = 64;
  localparam int SLOTS = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [3:0] OP_SPARE_LO = 4'd14;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  typedef struct {
    logic [31:0] top;
    logic [6:0]  depth;
    logic [31:0] pval;
    logic        pvalid;
    logic [2:0]  err;
  } word_result_t;

  // Scoreboard: carries its own copy of the stack machine and the expected results.
  class word_scoreboard;
    logic [31:0] stk [DEPTH];
    int unsigned sp;
    logic [31:0] vars [SLOTS];
    word_result_t pending[$];
    int errors;
    int checked;
    int prints;
    int err_seen [5];

    function void clear();
      sp = 0;
      foreach (vars[i]) vars[i] = '0;
      foreach (stk[i]) stk[i] = '0;
      pending.delete();
    endfunction

    // Execute one accepted word and queue its result.
    function void note_word(logic [3:0] op, logic [31:0] lit);
      word_result_t r;
      int unsigned need, grow;
      logic [31:0] a, b;
      logic signed [31:0] slot;
      need = 0;
      grow = 0;
      r.pval = '0;
      r.pvalid = 1'b0;
      r.err = sma_pkg::ERR_OK;
      if (op == sma_pkg::OP_PUSH) grow = 1;
      else if (op == sma_pkg::OP_PRINT || op == sma_pkg::OP_FETCH ||
               op == sma_pkg::OP_DROP) need = 1;
      else if (op == sma_pkg::OP_DUP) begin need = 1; grow = 1; end
      else if (op <= sma_pkg::OP_GT) need = 2;
      if (op > sma_pkg::OP_GT) begin
      end else if (sp < need) begin
        r.err = sma_pkg::ERR_UNDER;
      end else if (grow != 0 && sp >= DEPTH) begin
        r.err = sma_pkg::ERR_OVER;
      end else begin
        if (need == 2) begin
          b = stk[sp-1];
          a = stk[sp-2];
          sp = sp - 2;
        end else if (need == 1) begin
          b = stk[sp-1];
          sp = sp - 1;
        end
        case (op)
          sma_pkg::OP_PUSH: begin stk[sp] = lit; sp++; end
          sma_pkg::OP_ADD: begin stk[sp] = a + b; sp++; end
          sma_pkg::OP_SUB: begin stk[sp] = a - b; sp++; end
          sma_pkg::OP_MUL: begin stk[sp] = a * b; sp++; end
          sma_pkg::OP_DIV: begin
            if (b == 0) r.err = sma_pkg::ERR_DIV0;
            else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
              stk[sp] = a;
              sp++;
            end
            else begin stk[sp] = $signed(a) / $signed(b); sp++; end
          end
          sma_pkg::OP_PRINT: begin r.pval = b; r.pvalid = 1'b1; end
          sma_pkg::OP_STORE: begin
            slot = b;
            if (slot >= 0 && slot < SLOTS) vars[slot] = a;
            else r.err = sma_pkg::ERR_SLOT;
          end
          sma_pkg::OP_FETCH: begin
            slot = b;
            if (slot >= 0 && slot < SLOTS) begin stk[sp] = vars[slot]; sp++; end
            else r.err = sma_pkg::ERR_SLOT;
          end
          sma_pkg::OP_DUP: begin stk[sp] = b; stk[sp+1] = b; sp += 2; end
          sma_pkg::OP_DROP: ;
          sma_pkg::OP_SWAP: begin stk[sp] = b; stk[sp+1] = a; sp += 2; end
          sma_pkg::OP_EQ: begin stk[sp] = (a == b) ? 32'd1 : 32'd0; sp++; end
          sma_pkg::OP_LT: begin
            stk[sp] = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            sp++;
          end
          default: begin
            stk[sp] = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
            sp++;
          end
        endcase
      end
      r.top = (sp > 0) ? stk[sp-1] : 32'd0;
      r.depth = sp[6:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] top, logic [6:0] depth, logic [31:0] pval,
                               logic pvalid, logic [2:0] err);
      word_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (pvalid) prints++;
      if (err <= sma_pkg::ERR_SLOT) err_seen[err]++;
      if (top !== e.top) begin
        $display("%0t: top_value expected %h actual %h", $time, e.top, top);
        errors++;
      end
      if (depth !== e.depth) begin
        $display("%0t: stack_depth expected %0d actual %0d", $time, e.depth, depth);
        errors++;
      end
      if (pval !== e.pval) begin
        $display("%0t: printed_value expected %h actual %h", $time, e.pval, pval);
        errors++;
      end
      if (pvalid !== e.pvalid) begin
        $display("%0t: printed_valid expected %b actual %b", $time, e.pvalid, pvalid);
        errors++;
      end
      if (err !== e.err) begin
        $display("%0t: error_code expected %0d actual %0d", $time, e.err, err);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  opcode = '0;
  logic [31:0] literal = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] top_value;
  logic [6:0]  stack_depth;
  logic [31:0] printed_value;
  logic        printed_valid;
  logic [2:0]  error_code;

  stack_machine_alu_unit #(.STACK_DEPTH(DEPTH), .VAR_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .literal(literal),
    .out_valid(out_valid), .out_ready(out_ready),
    .top_value(top_value), .stack_depth(stack_depth),
    .printed_value(printed_value), .printed_valid(printed_valid),
    .error_code(error_code)
  );

  always #10 clk = ~clk;

  word_scoreboard sb = new();

  // Idle control: quiet windows switch off random gaps on either side.
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  bit recv_hold = 1'b0;
  bit stim_done = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;

  // Sample accepted items at the edge; the scoreboard sees pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(opcode, literal);
      if (out_valid && out_ready)
        sb.check_result(top_value, stack_depth, printed_value, printed_valid, error_code);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, none in the quiet window, stalled throughout the hold.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (recv_hold) out_ready <= 1'b0;
    else if (recv_quiet) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 31);
  end

  // Offer one item; hold valid and payload until it is accepted. Valid stays
  // high after acceptance so the next item can follow in the same step.
  task automatic send_word(logic [3:0] op, logic [31:0] lit);
    while (!send_quiet && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    literal <= lit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      4: return $urandom_range(SLOTS + 1);
      5: return 32'd0 - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal words with extra pushes to keep the stack populated; near full most pushes become drops.
  task automatic random_word();
    logic [3:0] op;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) op = sma_pkg::OP_PUSH;
    else if (r < 34) op = 4'($urandom_range(15));
    else op = 4'($urandom_range(sma_pkg::OP_GT));
    if (op == sma_pkg::OP_PUSH && sb.sp >= DEPTH - 2 && $urandom_range(9) != 0)
      op = sma_pkg::OP_DROP;
    send_word(op, (op == sma_pkg::OP_PUSH) ? pick_value() : $urandom);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    int k;
    sb.clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: underflow on empty, divide corners, slot range, spare opcodes, overflow.
    send_word(sma_pkg::OP_ADD, 32'hFFFF_FFFF);
    send_word(sma_pkg::OP_PRINT, 32'd0);
    send_word(sma_pkg::OP_PUSH, 32'h8000_0000);
    send_word(sma_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_word(sma_pkg::OP_DIV, 32'd0);
    send_word(sma_pkg::OP_PUSH, 32'd0);
    send_word(sma_pkg::OP_DIV, 32'd0);
    send_word(sma_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_word(sma_pkg::OP_PUSH, 32'hFFFF_FFF9);
    send_word(sma_pkg::OP_DIV, 32'd0);
    send_word(sma_pkg::OP_PUSH, 32'd63);
    send_word(sma_pkg::OP_STORE, 32'd0);
    send_word(sma_pkg::OP_PUSH, 32'd63);
    send_word(sma_pkg::OP_FETCH, 32'd0);
    send_word(sma_pkg::OP_PUSH, 32'd64);
    send_word(sma_pkg::OP_FETCH, 32'd0);
    send_word(sma_pkg::OP_PUSH, 32'h8000_0000);
    send_word(sma_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_word(sma_pkg::OP_STORE, 32'd0);
    send_word(OP_SPARE_LO, 32'd0);
    send_word(OP_SPARE_HI, 32'hFFFF_FFFF);
    send_word(sma_pkg::OP_PRINT, 32'd0);
    // Fill the stack with dups until the last one overflows.
    send_word(sma_pkg::OP_PUSH, 32'd5);
    for (k = 0; k < DEPTH; k++) send_word(sma_pkg::OP_DUP, 32'd0);

    // Long hold on the receiver while the sender keeps offering items.
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (k = 0; k < 20; k++) random_word();
    join

    for (k = 0; k < 1600; k++) begin
      send_quiet = (k >= 600 && k < 800);
      recv_quiet = send_quiet;
      random_word();
    end
    in_valid <= 1'b0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    drain();
    stim_done = 1'b1;
  end

  initial begin
    @(negedge rst);
    while (!stim_done) begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", sb.pending.size());
        $display("stack_machine_alu_unit_tb: FAIL");
        $finish;
      end
    end
    if (sb.pending.size() != 0) sb.errors++;
    $display("Ran %0d words, checked %0d results, %0d prints.", sent, sb.checked, sb.prints);
    $display("Errors seen: under %0d over %0d div0 %0d slot %0d; mismatches %0d.",
             sb.err_seen[sma_pkg::ERR_UNDER], sb.err_seen[sma_pkg::ERR_OVER],
             sb.err_seen[sma_pkg::ERR_DIV0], sb.err_seen[sma_pkg::ERR_SLOT], sb.errors);
    if (sb.errors == 0) $display("stack_machine_alu_unit_tb: PASS");
    else $display("stack_machine_alu_unit_tb: FAIL");
    $finish;
  end

endmodule
